@@ sv/fit_pkg.sv @@
// Shared types and constants for the face identifier table.
`timescale 1ns / 1ps

package fit_pkg;

   localparam int DEF_ENTRIES = 8;
   localparam int DEF_ID_BITS = 8;

   // Widest values the parameters allow; the packet and write bus carry these.
   localparam int ID_MAX_W   = 16;
   localparam int SLOT_MAX_W = 6;

   localparam int FACE_ID_W = 8;
   localparam int TYPE_W    = 4;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 3;
   localparam int SLOT_W    = 3;
   localparam int OCC_W     = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_FIND   = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_DUP     = 3'd1,
      ST_FULL    = 3'd2,
      ST_MISS    = 3'd3,
      ST_INVALID = 3'd4
   } status_type;

   // Item travelling down the row of cells, collecting the lookup results.
   typedef struct packed {
      logic                  valid;
      cmd_type               cmd;
      logic [ID_MAX_W-1:0]   id;
      logic [TYPE_W-1:0]     face_type;
      logic                  hit;
      logic [SLOT_MAX_W-1:0] hit_slot;
      logic [TYPE_W-1:0]     hit_type;
      logic                  free_found;
      logic [SLOT_MAX_W-1:0] free_slot;
   } pkt_type;

   // Broadcast write into one slot of the row.
   typedef struct packed {
      logic                  en;
      logic [SLOT_MAX_W-1:0] slot;
      logic [ID_MAX_W-1:0]   id;
      logic [TYPE_W-1:0]     face_type;
   } wr_type;

endpackage

@@ sv/fit_cell.sv @@
// One table slot: stores an entry and checks the passing item against it.
`timescale 1ns / 1ps

module fit_cell #(
   parameter int ID_BITS    = fit_pkg::DEF_ID_BITS,
   parameter int CELL_INDEX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  fit_pkg::pkt_type pkt_up,
   output fit_pkg::pkt_type pkt_dn,
   input  fit_pkg::wr_type  wr
);
   import fit_pkg::*;

   logic [ID_BITS-1:0] id_ff, id_in;
   logic [TYPE_W-1:0]  type_ff, type_in;
   pkt_type            pkt_ff, pkt_in;
   logic               mine;

   always_comb begin
      mine    = wr.en && (wr.slot == SLOT_MAX_W'(CELL_INDEX));
      id_in   = mine ? wr.id[ID_BITS-1:0] : id_ff;
      type_in = mine ? wr.face_type : type_ff;
   end

   always_comb begin
      pkt_in = pkt_up;
      if (pkt_up.valid) begin
         if (!pkt_up.hit && (pkt_up.id != '0) && (ID_MAX_W'(id_ff) == pkt_up.id)) begin
            pkt_in.hit      = 1'b1;
            pkt_in.hit_slot = SLOT_MAX_W'(CELL_INDEX);
            pkt_in.hit_type = type_ff;
         end
         if (!pkt_up.free_found && (id_ff == '0)) begin
            pkt_in.free_found = 1'b1;
            pkt_in.free_slot  = SLOT_MAX_W'(CELL_INDEX);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff        <= '0;
         type_ff      <= '0;
         pkt_ff.valid <= 1'b0;
      end else begin
         id_ff   <= id_in;
         type_ff <= type_in;
         if (advance) begin
            pkt_ff <= pkt_in;
         end
      end
   end

   assign pkt_dn = pkt_ff;

endmodule

@@ sv/face_id_table_unit.sv @@
// Top level of the face identifier table: cell row, commit logic, result register.
`timescale 1ns / 1ps

// Face identifier table. Each request item (find, add or remove one identifier)
// walks down a row of TABLE_ENTRIES cells, one cell per cycle, picking up the
// first matching slot and the lowest free slot; at the end of the row the
// operation commits, with a single write into the chosen cell for a successful
// add or remove, and the result is registered. One item is in the row at a time,
// so the next item is taken only after the current one commits at the end of the
// row. A finished result waits in the output register while the next item walks
// the row; the row stalls at its end only if that result is still untaken. The
// table clears at reset. Identifier zero is invalid for every command; command
// code three behaves as find.
module face_id_table_unit #(
   parameter int TABLE_ENTRIES = fit_pkg::DEF_ENTRIES,
   parameter int ID_BITS       = fit_pkg::DEF_ID_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] face_id, [11:8] face_type, [15:12] zero
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [2:0] status, [5:3] slot_index, [9:6] found_type,
                                    // [13:10] occupied_count, [15:14] zero
);
   import fit_pkg::*;

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   pkt_type pkt [TABLE_ENTRIES+1];
   pkt_type last;
   wr_type  cell_wr;
   logic [TABLE_ENTRIES-1:0] valid_vec;

   logic                busy_ff, busy_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [TYPE_W-1:0]   ftype_ff, ftype_in;
   logic [OCC_W-1:0]    occ_ff, occ_in;

   logic                accept, advance, commit;
   logic [ID_MAX_W-1:0] id_mask;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign last       = pkt[TABLE_ENTRIES];
   assign advance    = !(last.valid && rsp_valid_ff && !rsp_tready);
   assign commit     = last.valid && advance;

   // Only the low ID_BITS bits of face_id name an identifier.
   always_comb begin
      for (int b = 0; b < ID_MAX_W; b++) begin
         id_mask[b] = (b < ID_BITS && b < FACE_ID_W) ? req_tdata[b] : 1'b0;
      end
   end

   always_comb begin
      pkt[0]            = '0;
      pkt[0].valid      = accept;
      pkt[0].cmd        = cmd_type'(req_tuser);
      pkt[0].id         = id_mask;
      pkt[0].face_type  = req_tdata[11:8];
   end

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      fit_cell #(
         .ID_BITS    (ID_BITS),
         .CELL_INDEX (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .pkt_up  (pkt[i]),
         .pkt_dn  (pkt[i+1]),
         .wr      (cell_wr)
      );
      assign valid_vec[i] = pkt[i+1].valid;
   end

   always_comb begin
      cell_wr   = '0;
      status_in = ST_OK;
      slot_in   = '0;
      ftype_in  = '0;
      count_in  = count_ff;
      if (last.id == '0) begin
         status_in = ST_INVALID;
      end else begin
         unique case (last.cmd)
            CMD_ADD: begin
               if (last.hit) begin
                  status_in = ST_DUP;
               end else if (!last.free_found) begin
                  status_in = ST_FULL;
               end else begin
                  cell_wr.en        = commit;
                  cell_wr.slot      = last.free_slot;
                  cell_wr.id        = last.id;
                  cell_wr.face_type = last.face_type;
                  slot_in           = SLOT_W'(last.free_slot);
                  count_in          = count_ff + CNT_W'(1);
               end
            end
            CMD_REMOVE: begin
               if (last.hit) begin
                  cell_wr.en   = commit;
                  cell_wr.slot = last.hit_slot;
                  slot_in      = SLOT_W'(last.hit_slot);
                  count_in     = count_ff - CNT_W'(1);
               end else begin
                  status_in = ST_MISS;
               end
            end
            default: begin
               if (last.hit) begin
                  slot_in  = SLOT_W'(last.hit_slot);
                  ftype_in = last.hit_type;
               end else begin
                  status_in = ST_MISS;
               end
            end
         endcase
      end
      occ_in = OCC_W'(count_in);
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (commit) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         status_ff <= status_in;
         slot_ff   <= slot_in;
         ftype_ff  <= ftype_in;
         occ_ff    <= occ_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, occ_ff, ftype_ff, slot_ff, status_ff};

   a_single_item: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) <= 1)
      else $error("more than one item in the cell row");

   a_row_busy: assert property (@(posedge clock) disable iff (reset)
      (|valid_vec) |-> busy_ff)
      else $error("item in the cell row while not busy");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("occupied count above table size");

   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      cell_wr.en |-> (status_in == ST_OK) && commit)
      else $error("table write without a successful commit");

   a_commit_result: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_tvalid && !busy_ff)
      else $error("commit did not post a result");

endmodule

@@ tb/sv/face_id_table_unit_test.sv @@
// Self-checking stream testbench for the face identifier table.
`timescale 1ns / 1ps

module face_id_table_unit_test;
   import fit_pkg::*;

   localparam int ENTRIES     = DEF_ENTRIES;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 4 * (ENTRIES + 1);
   localparam logic [1:0] CMD_SPARE = 2'd3;   // unused code, behaves as find

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot_index;
      logic [TYPE_W-1:0] found_type;
      logic [OCC_W-1:0]  occupied_count;
   } face_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [7:0] face_id, [11:8] face_type, [15:12] zero
   logic [1:0]  req_tuser = '0;   // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [2:0] status, [5:3] slot_index, [9:6] found_type,
                                  // [13:10] occupied_count, [15:14] zero

   // Table image held by the predictor.
   logic [FACE_ID_W-1:0] table_ids [ENTRIES];
   logic [TYPE_W-1:0]    table_types [ENTRIES];

   face_result_type pending_results[$];
   int error_count   = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   face_id_table_unit #(
      .TABLE_ENTRIES(ENTRIES),
      .ID_BITS(DEF_ID_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Applies one table operation to the image and returns its result.
   function automatic face_result_type apply_face_op(input logic [1:0] cmd,
                                                     input logic [FACE_ID_W-1:0] id,
                                                     input logic [TYPE_W-1:0] ftype);
      face_result_type res;
      logic hit;
      logic have_free;
      int hit_slot;
      int free_slot;
      int occ;
      res = '{status: ST_OK, slot_index: '0, found_type: '0, occupied_count: '0};
      hit = 1'b0;
      have_free = 1'b0;
      hit_slot = 0;
      free_slot = 0;
      occ = 0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!hit && id != '0 && table_ids[i] == id) begin
            hit = 1'b1;
            hit_slot = i;
         end
         if (!have_free && table_ids[i] == '0) begin
            have_free = 1'b1;
            free_slot = i;
         end
      end
      if (id == '0) begin
         res.status = ST_INVALID;
      end else if (cmd == CMD_ADD) begin
         if (hit) begin
            res.status = ST_DUP;
         end else if (!have_free) begin
            res.status = ST_FULL;
         end else begin
            table_ids[free_slot] = id;
            table_types[free_slot] = ftype;
            res.slot_index = free_slot[SLOT_W-1:0];
         end
      end else if (cmd == CMD_REMOVE) begin
         if (hit) begin
            table_ids[hit_slot] = '0;
            table_types[hit_slot] = '0;
            res.slot_index = hit_slot[SLOT_W-1:0];
         end else begin
            res.status = ST_MISS;
         end
      end else begin
         if (hit) begin
            res.slot_index = hit_slot[SLOT_W-1:0];
            res.found_type = table_types[hit_slot];
         end else begin
            res.status = ST_MISS;
         end
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (table_ids[i] != '0) occ++;
      end
      res.occupied_count = occ[OCC_W-1:0];
      return res;
   endfunction

   // Valid stays high between back-to-back items; it only drops on an idle cycle.
   task automatic send_item(input logic [1:0] cmd, input logic [FACE_ID_W-1:0] id,
                            input logic [TYPE_W-1:0] ftype);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, ftype, id};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(apply_face_op(cmd, id, ftype));
   endtask

   task automatic test_invalid_id();
      send_item(CMD_FIND, 8'h00, 4'h0);
      send_item(CMD_ADD, 8'h00, 4'hF);
      send_item(CMD_REMOVE, 8'h00, 4'hA);
      send_item(CMD_SPARE, 8'h00, 4'h5);
   endtask

   task automatic test_miss_on_empty();
      send_item(CMD_FIND, 8'hFF, 4'hF);
      send_item(CMD_REMOVE, 8'h01, 4'h0);
   endtask

   task automatic test_add_find_remove();
      send_item(CMD_ADD, 8'hFF, 4'hF);
      send_item(CMD_ADD, 8'h01, 4'h0);
      send_item(CMD_ADD, 8'h01, 4'h7);      // duplicate
      send_item(CMD_FIND, 8'hFF, 4'h0);
      send_item(CMD_SPARE, 8'h01, 4'hC);
      send_item(CMD_REMOVE, 8'hFF, 4'h3);
      send_item(CMD_FIND, 8'hFF, 4'h0);
   endtask

   task automatic test_table_full();
      // one slot already taken by id 0x01
      for (int i = 0; i < ENTRIES - 1; i++) begin
         send_item(CMD_ADD, 8'h80 + 8'(i), 4'(i + 8));
      end
      send_item(CMD_ADD, 8'h55, 4'h9);      // no free slot
      send_item(CMD_ADD, 8'h82, 4'h1);      // duplicate wins over full
      send_item(CMD_REMOVE, 8'h83, 4'h0);
      send_item(CMD_ADD, 8'hAA, 4'h6);      // refills the freed slot
      send_item(CMD_FIND, 8'h86, 4'h0);
   endtask

   // Mostly ids from a small pool so adds, hits and a full table keep recurring.
   task automatic test_random_traffic(input int count);
      int pick;
      logic [1:0] cmd;
      logic [FACE_ID_W-1:0] id;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 40) cmd = CMD_ADD;
         else if (pick < 70) cmd = CMD_REMOVE;
         else if (pick < 95) cmd = CMD_FIND;
         else cmd = CMD_SPARE;
         pick = $urandom_range(99);
         if (pick < 65) id = 8'($urandom_range(12, 1));
         else if (pick < 68) id = '0;
         else id = 8'($urandom_range(255));
         send_item(cmd, id, 4'($urandom_range(15)));
      end
   endtask

   always @(posedge clock) begin
      face_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result item 0x%04h", rsp_tdata);
            error_count++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_tdata[2:0] != exp_res.status) begin
               $error("status: expected %0d, actual %0d", exp_res.status, rsp_tdata[2:0]);
               error_count++;
            end
            if (rsp_tdata[5:3] != exp_res.slot_index) begin
               $error("slot_index: expected %0d, actual %0d", exp_res.slot_index,
                      rsp_tdata[5:3]);
               error_count++;
            end
            if (rsp_tdata[9:6] != exp_res.found_type) begin
               $error("found_type: expected %0d, actual %0d", exp_res.found_type,
                      rsp_tdata[9:6]);
               error_count++;
            end
            if (rsp_tdata[13:10] != exp_res.occupied_count) begin
               $error("occupied_count: expected %0d, actual %0d", exp_res.occupied_count,
                      rsp_tdata[13:10]);
               error_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         table_ids[i] = '0;
         table_types[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 30;
      recv_idle_pct = 48;
      test_invalid_id();
      test_miss_on_empty();
      test_add_find_remove();
      test_table_full();
      test_random_traffic(200);

      send_idle_pct = 48;
      recv_idle_pct = 30;
      test_random_traffic(200);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(225);

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ face_id_table_unit.f @@
sv/fit_pkg.sv
sv/fit_cell.sv
sv/face_id_table_unit.sv
tb/sv/face_id_table_unit_test.sv
